FILE: rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, constants and lead-byte decode for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    localparam int CP_W      = 21;   // decoded code point width
    localparam int PART_W    = 15;   // partial value held between bytes
    localparam int CNT_W     = 3;    // byte count / sequence length width
    localparam int PEND_W    = 2;    // continuations still due
    localparam int QDEPTH    = 4;    // result queue slots
    localparam int QCNT_W    = 3;    // holds 0..QDEPTH
    localparam int MAX_RES   = 2;    // results one byte can cause

    // Byte classes: mask and match patterns
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Payload masks per byte kind
    localparam logic [7:0] CONT_DATA  = 8'h3F;
    localparam logic [7:0] LEAD2_DATA = 8'h1F;
    localparam logic [7:0] LEAD3_DATA = 8'h0F;
    localparam logic [7:0] LEAD4_DATA = 8'h07;

    typedef enum logic
    {
        KIND_CHAR  = 1'b0,
        KIND_ERROR = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [CP_W-1:0]  code_point;
        kind_t            kind;
        logic [CNT_W-1:0] count;
        logic             last;
    } result_t;

    // Outcome of decoding a byte with no sequence open
    typedef struct packed
    {
        logic              emit;      // gives a result right away
        result_t           res;
        logic [PEND_W-1:0] pending;   // nonzero when a sequence opens
        logic [PART_W-1:0] partial;
        logic [CNT_W-1:0]  length;
    } lead_t;

    function automatic result_t error_result();
        result_t r;
        r.code_point = '0;
        r.kind       = KIND_ERROR;
        r.count      = '0;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic lead_t decode_lead(input logic [7:0] b);
        lead_t l;
        l.emit    = 1'b0;
        l.res     = error_result();
        l.pending = '0;
        l.partial = '0;
        l.length  = '0;
        if ((b & ASCII_MASK) == 8'h00)
        begin
            l.emit           = 1'b1;
            l.res.code_point = CP_W'(b);
            l.res.kind       = KIND_CHAR;
            l.res.count      = CNT_W'(1);
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            l.pending = PEND_W'(1);
            l.partial = PART_W'(b & LEAD2_DATA);
            l.length  = CNT_W'(2);
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            l.pending = PEND_W'(2);
            l.partial = PART_W'(b & LEAD3_DATA);
            l.length  = CNT_W'(3);
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            l.pending = PEND_W'(3);
            l.partial = PART_W'(b & LEAD4_DATA);
            l.length  = CNT_W'(4);
        end
        else
        begin
            // stray continuation or invalid lead
            l.emit = 1'b1;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// Sequence state registers and the per-byte decode step. Produces up to two
// results per byte, packed from slot 0, with the final one marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_decode
    import u8d_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,       // consume the held byte
    input  wire logic [7:0]           text_byte,
    input  wire logic                 end_of_text,
    output result_t                   res [MAX_RES],
    output logic [1:0]                res_num
);

    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [PART_W-1:0] partial_reg, partial_next;
    logic [CNT_W-1:0]  length_reg,  length_next;

    lead_t             lead;
    logic [CP_W-1:0]   joined;
    logic [PEND_W-1:0] pend_dec;
    result_t           done_res;

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            partial_reg <= '0;
            length_reg  <= '0;
        end
        else if (step)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            length_reg  <= length_next;
        end
    end

    assign lead     = decode_lead(text_byte);
    assign joined   = {partial_reg, text_byte[5:0] & CONT_DATA[5:0]};
    assign pend_dec = pending_reg - PEND_W'(1);

    always_comb
    begin
        done_res            = error_result();
        done_res.code_point = joined;
        done_res.kind       = KIND_CHAR;
        done_res.count      = length_reg;
    end

    // Decode step: gather results in order, then flag the last one
    always_comb
    begin
        res[0]       = error_result();
        res[1]       = error_result();
        res_num      = 2'd0;
        pending_next = pending_reg;
        partial_next = partial_reg;
        length_next  = length_reg;

        if (pending_reg != '0 && (text_byte & CONT_MASK) == CONT_CODE)
        begin
            // continuation of the open sequence
            pending_next = pend_dec;
            if (pend_dec == '0)
            begin
                res[0]       = done_res;
                res_num      = 2'd1;
                partial_next = '0;
                length_next  = '0;
            end
            else
            begin
                partial_next = joined[PART_W-1:0];
            end
        end
        else
        begin
            // broken sequence reports first, then the byte is a fresh lead
            if (pending_reg != '0)
            begin
                res[0]  = error_result();
                res_num = 2'd1;
            end
            pending_next = lead.pending;
            partial_next = lead.partial;
            length_next  = lead.length;
            if (lead.emit)
            begin
                res[res_num[0]] = lead.res;
                res_num         = res_num + 2'd1;
            end
        end

        // unfinished sequence at end of text
        if (end_of_text && pending_next != '0)
        begin
            res[res_num[0]] = error_result();
            res_num         = res_num + 2'd1;
            pending_next    = '0;
            partial_next    = '0;
            length_next     = '0;
        end

        if (res_num == 2'd1)
        begin
            res[0].last = 1'b1;
        end
        else if (res_num == 2'd2)
        begin
            res[1].last = 1'b1;
        end
    end

    // Assertions
    a_len_matches_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != '0) |-> (length_reg > CNT_W'(pending_reg)))
        else $error("sequence length not above pending count");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == '0) |-> (length_reg == '0 && partial_reg == '0))
        else $error("state not cleared with no sequence open");

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> (res_num != 2'd3))
        else $error("more than two results for one byte");

endmodule

`default_nettype wire

FILE: rtl/u8d_res_queue.sv
// ----------------------------------------------------------------------------
// u8d_res_queue
// Four-slot result queue. Takes up to two results per cycle, hands out one
// from slot 0; slots shift down on each output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_res_queue
    import u8d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire result_t     push_res [MAX_RES],
    input  wire logic [1:0]  push_num,
    input  wire logic        pop,
    output result_t          head,
    output logic             not_empty,
    output logic             room_for_two
);

    result_t            slot_reg  [QDEPTH];
    result_t            slot_next [QDEPTH];
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QCNT_W-1:0]  base;

    assign base       = count_reg - QCNT_W'(pop);
    assign count_next = base + QCNT_W'(push_num);

    // Shift on pop, then write new results behind the survivors
    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && i < QDEPTH - 1)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            else
            begin
                slot_next[i] = slot_reg[i];
            end
            if (push_num != 2'd0 && base == QCNT_W'(i))
            begin
                slot_next[i] = push_res[0];
            end
            if (push_num == 2'd2 && base + QCNT_W'(1) == QCNT_W'(i))
            begin
                slot_next[i] = push_res[1];
            end
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    // Fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head         = slot_reg[0];
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= QCNT_W'(QDEPTH - MAX_RES));

    // Assertions
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_num != 2'd0) |-> room_for_two)
        else $error("push into a queue without room");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder, one byte in per transfer, code points out.
// ----------------------------------------------------------------------------
// Takes one text byte per input transfer and sustains one byte per clock
// while the result queue has room. A byte is held in the input register, is
// decoded in a single pass against the sequence state, and its results
// (none, one or two) enter a four-slot result queue. Output is one result
// per clock while out_stall is low, so bytes that cause two results (a
// broken sequence followed by a character or an error, or by a new lead cut
// off at end of text) slow the input when the output keeps up. The input
// side stalls only while the held byte cannot be decoded because the queue
// has fewer than two free slots. Error results carry code point and byte
// count of zero; last_of_run marks the final result of each byte.
`default_nettype none

module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // byte input
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        text_byte,
    input  wire logic              end_of_text,
    // result output
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CP_W-1:0]        code_point,
    output logic                   result_kind,
    output logic [CNT_W-1:0]       byte_count,
    output logic                   last_of_run
);

    logic       full_reg, full_next;
    logic [7:0] byte_reg;
    logic       eot_reg;
    logic       step;
    logic       in_xfer;
    logic       out_xfer;
    logic       room_for_two;
    result_t    res [MAX_RES];
    logic [1:0] res_num;
    result_t    head;

    assign step      = full_reg && room_for_two;
    assign in_stall  = full_reg && !room_for_two;
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;
    assign full_next = in_xfer ? 1'b1 : (step ? 1'b0 : full_reg);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

    // Decode step
    u8d_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text_byte   (byte_reg),
        .end_of_text (eot_reg),
        .res         (res),
        .res_num     (res_num)
    );

    // Result queue
    u8d_res_queue u_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_res     (res),
        .push_num     (step ? res_num : 2'd0),
        .pop          (out_xfer),
        .head         (head),
        .not_empty    (out_valid),
        .room_for_two (room_for_two)
    );

    assign code_point  = head.code_point;
    assign result_kind = head.kind;
    assign byte_count  = head.count;
    assign last_of_run = head.last;

    // Assertions
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_ERROR) |-> (code_point == '0 && byte_count == '0))
        else $error("error result with nonzero payload");

    a_char_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_CHAR) |->
            (byte_count == CNT_W'(1) || byte_count == CNT_W'(2) ||
             byte_count == CNT_W'(3) || byte_count == CNT_W'(4)))
        else $error("character result with bad byte count");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && !step) |=> (full_reg && $stable(byte_reg)))
        else $error("held byte lost before decode");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// Bytes are fed through the valid/stall input channel. Each accepted byte runs
// through a local decoder model that queues the code points and error results
// it should cause. Every result transfer is compared field by field against
// the oldest queued entry. Directed cases cover the byte classes and the error
// paths. A random text phase mixes well-formed characters with cut-off
// sequences and noise. Two further phases fill the result queue behind a long
// output hold and pause the input until all results are out.
`default_nettype none

module tb_top
    import u8d_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  RANDOM_BYTES = 500;
    localparam int  MAX_REPORTS  = 10;
    localparam logic [8:0] EOT_FLAG = 9'h100;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic [7:0]       text_byte   = 8'h00;
    logic             end_of_text = 1'b0;
    logic             out_valid;
    logic             out_stall;
    logic [CP_W-1:0]  code_point;
    logic             result_kind;
    logic [CNT_W-1:0] byte_count;
    logic             last_of_run;

    // output back-pressure: per-result random wait plus a long hold
    logic rand_stall = 1'b0;
    logic hold_stall = 1'b0;
    assign out_stall = rand_stall | hold_stall;

    // idling switches for each side
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_wait = 0;

    // decoder model state
    logic [PEND_W-1:0] dec_pending = '0;
    logic [PART_W-1:0] dec_partial = '0;
    logic [CNT_W-1:0]  dec_length  = '0;

    result_t step_res[$];
    result_t decoded_due[$];

    int fail_count  = 0;
    int cycle_count = 0;

    utf8_stream_decoder uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .result_kind (result_kind),
        .byte_count  (byte_count),
        .last_of_run (last_of_run)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic result_t make_result(logic [CP_W-1:0] cp, kind_t k,
                                            logic [CNT_W-1:0] n);
        result_t r;
        r.code_point = cp;
        r.kind       = k;
        r.count      = n;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic void clear_sequence();
        dec_pending = '0;
        dec_partial = '0;
        dec_length  = '0;
    endfunction

    // byte seen with no sequence open
    function automatic void start_char(logic [7:0] b);
        casez (b)
            8'b0???????:
                step_res.push_back(make_result(CP_W'(b), KIND_CHAR, 3'd1));
            8'b110?????:
            begin
                dec_pending = 2'd1;
                dec_partial = PART_W'(b[4:0]);
                dec_length  = 3'd2;
            end
            8'b1110????:
            begin
                dec_pending = 2'd2;
                dec_partial = PART_W'(b[3:0]);
                dec_length  = 3'd3;
            end
            8'b11110???:
            begin
                dec_pending = 2'd3;
                dec_partial = PART_W'(b[2:0]);
                dec_length  = 3'd4;
            end
            default:
                step_res.push_back(make_result('0, KIND_ERROR, 3'd0));
        endcase
    endfunction

    // queue the results one accepted byte causes
    function automatic void decode_byte(logic [7:0] b, logic eot);
        logic [CP_W-1:0] acc;
        step_res.delete();
        if (dec_pending != '0)
        begin
            if (b[7:6] == 2'b10)
            begin
                acc = {dec_partial, b[5:0]};
                dec_pending = dec_pending - 2'd1;
                if (dec_pending == '0)
                begin
                    step_res.push_back(make_result(acc, KIND_CHAR, dec_length));
                    clear_sequence();
                end
                else
                begin
                    dec_partial = acc[PART_W-1:0];
                end
            end
            else
            begin
                // broken sequence, then the byte starts over
                step_res.push_back(make_result('0, KIND_ERROR, 3'd0));
                clear_sequence();
                start_char(b);
            end
        end
        else
        begin
            start_char(b);
        end
        // truncated at end of text
        if (eot && dec_pending != '0)
        begin
            step_res.push_back(make_result('0, KIND_ERROR, 3'd0));
            clear_sequence();
        end
        if (step_res.size() > 0)
            step_res[step_res.size()-1].last = 1'b1;
        foreach (step_res[i])
            decoded_due.push_back(step_res[i]);
    endfunction

    // ------------------------------------------------------------------
    // Result checking and random output stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: cp=%h kind=%0d cnt=%0d last=%0d",
                             code_point, result_kind, byte_count, last_of_run);
            end
            else
            begin
                want = decoded_due.pop_front();
                if (code_point !== want.code_point || result_kind !== logic'(want.kind)
                    || byte_count !== want.count || last_of_run !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: exp cp=%h kind=%0d cnt=%0d last=%0d,",
                                 want.code_point, want.kind, want.count, want.last,
                                 " got cp=%h kind=%0d cnt=%0d last=%0d",
                                 code_point, result_kind, byte_count, last_of_run);
                end
            end
            rx_wait = rx_idle ? $urandom_range(0, 4) : 0;
        end
        if (rx_wait > 0)
        begin
            rand_stall <= 1'b1;
            rx_wait--;
        end
        else
        begin
            rand_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------
    // one byte transfer; valid stays high for a back-to-back next byte
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b, eot);
    endtask

    // drop valid, then wait for every result
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_due.size() != 0)
            @(posedge clk);
    endtask

    // long output hold, counted here while the input keeps going
    task automatic hold_output(input int cycles);
        hold_stall <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_stall <= 1'b0;
    endtask

    // one character of random text: mostly well formed, some cut off, some noise
    task automatic send_random_char(inout int sent);
        int         pick;
        int         len;
        int         conts;
        logic [7:0] rb;
        pick = $urandom_range(0, 99);
        if (pick < 85)
        begin
            len = $urandom_range(1, 4);
            rb  = $urandom;
            case (len)
                1: rb = {1'b0, rb[6:0]};
                2: rb = {3'b110, rb[4:0]};
                3: rb = {4'b1110, rb[3:0]};
                default: rb = {5'b11110, rb[2:0]};
            endcase
            // cut-off sequences drop some continuations
            conts = (pick < 70) ? len - 1 : $urandom_range(0, len - 1);
            send_byte(rb, $urandom_range(0, 19) == 0);
            sent++;
            repeat (conts)
            begin
                rb = $urandom;
                send_byte({2'b10, rb[5:0]}, $urandom_range(0, 19) == 0);
                sent++;
            end
        end
        else
        begin
            rb = $urandom;
            send_byte(rb, $urandom_range(0, 9) == 0);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [8:0] cases[] = '{
            9'h000, 9'h07F,                     // null byte, top of ASCII
            9'h0C2, 9'h0A9,                     // two-byte character
            9'h0E2, 9'h082, 9'h0AC,             // three-byte character
            9'h0F0, 9'h09F, 9'h098, 9'h080,     // four-byte character
            9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,     // largest four-byte value
            9'h080, 9'h0BF,                     // stray continuations
            9'h0F8, 9'h0FF,                     // invalid leads
            9'h0E2, 9'h041,                     // broken by ASCII
            9'h0C3, 9'h0FF,                     // broken by invalid lead
            9'h0F0, EOT_FLAG | 9'h090,          // truncated at end
            9'h0E2, EOT_FLAG | 9'h0C3,          // broken, new lead cut at end
            EOT_FLAG | 9'h041                   // end on a complete character
        };
        foreach (cases[i])
            send_byte(cases[i][7:0], cases[i][8]);
        wait_drained();
    endtask

    task automatic test_random_text();
        int sent;
        int chunk_end;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            tx_idle   = $urandom_range(0, 3) != 0;
            rx_idle   = $urandom_range(0, 3) != 0;
            chunk_end = sent + 50;
            while (sent < chunk_end)
                send_random_char(sent);
        end
        wait_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // broken sequences give two results on the breaking byte and fill the result queue
    task automatic test_output_backlog();
        logic [7:0] rb;
        tx_idle = 1'b0;
        fork
            hold_output(60);
            begin
                repeat (20)
                begin
                    rb = $urandom;
                    send_byte({3'b110, rb[4:0]}, 1'b0);
                    send_byte({1'b0, rb[6:0]}, 1'b0);
                end
            end
        join
        wait_drained();
        tx_idle = 1'b1;
    endtask

    // input stops until every result is out, then resumes
    task automatic test_pause_for_drain();
        int sent;
        sent = 0;
        repeat (3)
        begin
            while (sent < 15)
                send_random_char(sent);
            wait_drained();
            sent = 0;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_text();
        test_output_backlog();
        test_pause_for_drain();

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && decoded_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
